/* src/joint_limit_braking_planner_unit_defines.svh */
// Assertion macros for the joint limit braking planner checker.
`ifndef JOINT_LIMIT_BRAKING_PLANNER_UNIT_DEFINES_SVH
`define JOINT_LIMIT_BRAKING_PLANNER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define JLBP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define JLBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* src/jlbp_pkg.sv */
// Shared constants, register codes and payload types of the braking planner.
package jlbp_pkg;

    localparam int FRAC_BITS = 16;

    // register indexes
    localparam logic [2:0] REG_BUFFER_FACTOR  = 3'd0;
    localparam logic [2:0] REG_WEIGHT_SCALE   = 3'd1;
    localparam logic [2:0] REG_WEIGHT_CEILING = 3'd2;
    localparam logic [2:0] REG_CONTROL_PERIOD = 3'd3;

    localparam logic [30:0] BUFFER_FACTOR_RST  = 31'd131072;
    localparam logic [30:0] WEIGHT_SCALE_RST   = 31'd6554;
    localparam logic [30:0] WEIGHT_CEILING_RST = 31'd655360;
    localparam logic [16:0] CONTROL_PERIOD_RST = 17'd655;

    // limit case codes
    localparam logic [2:0] LC_FREE       = 3'd0;
    localparam logic [2:0] LC_NEAR_UPPER = 3'd1;
    localparam logic [2:0] LC_AT_UPPER   = 3'd2;
    localparam logic [2:0] LC_NEAR_LOWER = 3'd3;
    localparam logic [2:0] LC_AT_LOWER   = 3'd4;

    localparam int VSQ_W  = 63;  // |v|^2 fits 63 bits
    localparam int DIST_W = 34;  // signed distance to limit
    localparam int DVP_W  = 48;  // control_period * accel

    // rides along the stop-distance divider
    typedef struct packed {
        logic [5:0]         jn;
        logic signed [31:0] vel;
        logic               up;
        logic               dist_neg;
        logic               dist_zero;
        logic               vsq_nz;
        logic               inactive;
        logic signed [31:0] pos;
        logic [30:0]        amax;
    } stop_pay_t;

    // rides along the weight divider
    typedef struct packed {
        logic [5:0]         jn;
        logic signed [31:0] vel;
        logic               up;
        logic               inactive;
        logic signed [31:0] pos;
        logic               over;
        logic               full;
        logic               den_zero;
        logic [DVP_W-1:0]   dvp;
    } wgt_pay_t;

endpackage

/* src/jlbp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module jlbp_div #(
    parameter int NUM_W = 63,
    parameter int DEN_W = 31,
    parameter int PAY_W = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [PAY_W-1:0] pay,
    output logic             out_valid,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem,
    output logic [PAY_W-1:0] out_pay
);

    logic [NUM_W:1]   vld_reg;
    logic [DEN_W-1:0] rem_reg [1:NUM_W];
    logic [NUM_W-1:0] nq_reg  [1:NUM_W];
    logic [DEN_W-1:0] den_reg [1:NUM_W];
    logic [PAY_W-1:0] pay_reg [1:NUM_W];

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic             vld_in;
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [DEN_W-1:0] den_in;
        logic [PAY_W-1:0] pay_in;
        logic [DEN_W:0]   sh;
        logic             ge;

        if (g == 0) begin : g_first
            assign vld_in = in_valid;
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
            assign pay_in = pay;
        end else begin : g_next
            assign vld_in = vld_reg[g];
            assign rem_in = rem_reg[g];
            assign nq_in  = nq_reg[g];
            assign den_in = den_reg[g];
            assign pay_in = pay_reg[g];
        end

        assign sh = {rem_in, nq_in[NUM_W-1]};
        assign ge = sh >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g+1] <= 1'b0;
            end else if (en) begin
                vld_reg[g+1] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g+1] <= ge ? DEN_W'(sh - {1'b0, den_in}) : sh[DEN_W-1:0];
                nq_reg[g+1]  <= {nq_in[NUM_W-2:0], ge};
                den_reg[g+1] <= den_in;
                pay_reg[g+1] <= pay_in;
            end
        end
    end

    assign out_valid = vld_reg[NUM_W];
    assign quo       = nq_reg[NUM_W];
    assign rem       = rem_reg[NUM_W];
    assign out_pay   = pay_reg[NUM_W];

endmodule

/* src/joint_limit_braking_planner_unit.sv */
// Joint limit braking planner: one joint per transaction, deep pipeline.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------------
//  s_      | in  | s_tvalid / s_tready | joint, position, velocity, limits, decel
//  m_      | out | m_tvalid / m_tready | echo, target pos/vel, weight; flags in tuser
//  cfg_    | in  | cfg_valid/cfg_ready | register index, write data
//
// Throughput: one transaction per cycle while m_ is not stalled. Depth is set
// by the divider pipelines (stop distance beside planning accel, then weight).
// Reset (aresetn low, synchronous) empties all valid bits and loads the
// register defaults. A stall on m_ freezes every stage at once; s_tready
// drops in the same cycle, so nothing is dropped or repeated.
module joint_limit_braking_planner_unit #(
    parameter int FRAC_BITS = jlbp_pkg::FRAC_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: joint_number[5:0], position[37:6], velocity[69:38],
    //          lower_limit[101:70], upper_limit[133:102], max_decel[164:134]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [167:0] s_tdata,
    // m_tdata: joint_echo[5:0], target_position[37:6],
    //          target_velocity[69:38], task_weight[101:70]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,
    // m_tuser: active[0], limit_case[3:1]
    output logic [3:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int VW = jlbp_pkg::VSQ_W;
    localparam int DW = jlbp_pkg::DIST_W;
    localparam int PW = jlbp_pkg::DVP_W;
    localparam int SW = PW + 2;   // velocity update sum

    // ---------------- configuration registers ----------------
    logic [30:0] buffer_factor_reg, weight_scale_reg, weight_ceiling_reg;
    logic [16:0] control_period_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_factor_reg  <= jlbp_pkg::BUFFER_FACTOR_RST;
            weight_scale_reg   <= jlbp_pkg::WEIGHT_SCALE_RST;
            weight_ceiling_reg <= jlbp_pkg::WEIGHT_CEILING_RST;
            control_period_reg <= jlbp_pkg::CONTROL_PERIOD_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                jlbp_pkg::REG_BUFFER_FACTOR:  buffer_factor_reg  <= cfg_data[30:0];
                jlbp_pkg::REG_WEIGHT_SCALE:   weight_scale_reg   <= cfg_data[30:0];
                jlbp_pkg::REG_WEIGHT_CEILING: weight_ceiling_reg <= cfg_data[30:0];
                jlbp_pkg::REG_CONTROL_PERIOD: control_period_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances together
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: unpack, direction, distance, clamp ----------------
    logic [5:0]         in_jn;
    logic signed [31:0] in_j, in_v, in_lo, in_hi;
    logic [30:0]        in_amax;
    logic               in_up;
    logic signed [DW-1:0] in_dist;
    logic [31:0]        in_vmag;
    logic signed [31:0] in_pos;

    assign in_jn   = s_tdata[5:0];
    assign in_j    = s_tdata[37:6];
    assign in_v    = s_tdata[69:38];
    assign in_lo   = s_tdata[101:70];
    assign in_hi   = s_tdata[133:102];
    assign in_amax = s_tdata[164:134];
    assign in_up   = !in_v[31] && (in_v != '0);
    assign in_vmag = in_v[31] ? 32'(-in_v) : in_v;
    assign in_dist = in_up ? (DW'(in_hi) - DW'(in_j)) : (DW'(in_j) - DW'(in_lo));
    assign in_pos  = (in_j > in_hi) ? in_hi : ((in_j < in_lo) ? in_lo : in_j);

    logic                 s1_valid_reg;
    logic [5:0]           s1_jn_reg;
    logic signed [31:0]   s1_v_reg, s1_pos_reg;
    logic                 s1_up_reg, s1_inactive_reg;
    logic signed [DW-1:0] s1_dist_reg;
    logic [31:0]          s1_vmag_reg;
    logic [30:0]          s1_amax_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_jn_reg       <= in_jn;
            s1_v_reg        <= in_v;
            s1_pos_reg      <= in_pos;
            s1_up_reg       <= in_up;
            s1_inactive_reg <= in_hi <= in_lo;
            s1_dist_reg     <= in_dist;
            s1_vmag_reg     <= in_vmag;
            s1_amax_reg     <= in_amax;
        end
    end

    // ---------------- stage 2: v^2, divider operands ----------------
    logic [63:0]   s1_vsq_full;
    logic          s1_dist_pos;
    assign s1_vsq_full = 64'(s1_vmag_reg) * 64'(s1_vmag_reg);
    assign s1_dist_pos = !s1_dist_reg[DW-1] && (s1_dist_reg != '0);

    logic               s2_valid_reg;
    logic [VW-1:0]      s2_vsq_reg;
    logic [DW-1:0]      s2_den_reg;
    logic [VW-1:0]      s2_numa_reg;
    jlbp_pkg::stop_pay_t s2_pay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_vsq_reg  <= s1_vsq_full[VW-1:0];
            // 2*dist; a harmless 1 where dist is not positive
            s2_den_reg  <= s1_dist_pos ? {s1_dist_reg[DW-2:0], 1'b0} : DW'(1);
            s2_numa_reg <= VW'(s1_amax_reg) << FRAC_BITS;
            s2_pay_reg.jn        <= s1_jn_reg;
            s2_pay_reg.vel       <= s1_v_reg;
            s2_pay_reg.up        <= s1_up_reg;
            s2_pay_reg.dist_neg  <= s1_dist_reg[DW-1];
            s2_pay_reg.dist_zero <= s1_dist_reg == '0;
            s2_pay_reg.vsq_nz    <= s1_vmag_reg != '0;
            s2_pay_reg.inactive  <= s1_inactive_reg;
            s2_pay_reg.pos       <= s1_pos_reg;
            s2_pay_reg.amax      <= s1_amax_reg;
        end
    end

    // ---------------- dividers: planning accel and stop accel ----------------
    logic               da_valid, db_valid;
    logic [VW-1:0]      da_quo, db_quo;
    logic [30:0]        da_rem;
    logic [DW-1:0]      db_rem;
    logic [30:0]        da_pay;
    jlbp_pkg::stop_pay_t db_pay;

    // a = (max_decel << FRAC_BITS) / buffer_factor
    jlbp_div #(.NUM_W(VW), .DEN_W(31), .PAY_W(31)) u_div_accel (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .in_valid(s2_valid_reg), .num(s2_numa_reg), .den(buffer_factor_reg),
        .pay(s2_pay_reg.amax),
        .out_valid(da_valid), .quo(da_quo), .rem(da_rem), .out_pay(da_pay)
    );

    // alim = v^2 / (2*dist), remainder feeds the exact overshoot test
    jlbp_div #(.NUM_W(VW), .DEN_W(DW), .PAY_W($bits(jlbp_pkg::stop_pay_t))) u_div_stop (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .in_valid(s2_valid_reg), .num(s2_vsq_reg), .den(s2_den_reg), .pay(s2_pay_reg),
        .out_valid(db_valid), .quo(db_quo), .rem(db_rem), .out_pay(db_pay)
    );

    // ---------------- stage 3: overshoot, braking accel, weight operands ----------------
    logic [VW-1:0] st_a;
    logic          st_over, st_fit, st_full;
    logic [30:0]   st_ades, st_diff, st_den;

    assign st_a = (buffer_factor_reg == '0) ? '0 : da_quo;
    always_comb begin
        if (db_pay.dist_neg) begin
            st_over = 1'b1;
        end else if (db_pay.dist_zero) begin
            st_over = db_pay.vsq_nz;
        end else begin
            // v^2/(2*dist) > a exactly
            st_over = (db_quo > st_a) || ((db_quo == st_a) && (db_rem != '0));
        end
    end
    assign st_fit  = !db_pay.dist_neg && !db_pay.dist_zero && (db_quo <= VW'(da_pay));
    assign st_full = !st_fit;
    assign st_ades = !st_over ? '0 : (st_full ? da_pay : db_quo[30:0]);
    assign st_diff = (db_quo > st_a) ? 31'(db_quo - st_a) : '0;
    assign st_den  = 31'(da_pay - db_quo[30:0]);

    logic               s3_valid_reg;
    logic [30:0]        s3_ades_reg, s3_diff_reg, s3_den_reg;
    jlbp_pkg::wgt_pay_t s3_pay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= db_valid && da_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_ades_reg          <= st_ades;
            s3_diff_reg          <= st_diff;
            s3_den_reg           <= st_fit ? st_den : 31'd1;
            s3_pay_reg.jn        <= db_pay.jn;
            s3_pay_reg.vel       <= db_pay.vel;
            s3_pay_reg.up        <= db_pay.up;
            s3_pay_reg.inactive  <= db_pay.inactive;
            s3_pay_reg.pos       <= db_pay.pos;
            s3_pay_reg.over      <= st_over;
            s3_pay_reg.full      <= st_full;
            s3_pay_reg.den_zero  <= st_fit && (st_den == '0);
            s3_pay_reg.dvp       <= '0;
        end
    end

    // ---------------- stage 4: products ----------------
    logic               s4_valid_reg;
    logic [61:0]        s4_wnum_reg;
    logic [30:0]        s4_den_reg;
    jlbp_pkg::wgt_pay_t s4_pay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_wnum_reg         <= 62'(weight_scale_reg) * 62'(s3_diff_reg);
            s4_den_reg          <= s3_den_reg;
            s4_pay_reg.jn       <= s3_pay_reg.jn;
            s4_pay_reg.vel      <= s3_pay_reg.vel;
            s4_pay_reg.up       <= s3_pay_reg.up;
            s4_pay_reg.inactive <= s3_pay_reg.inactive;
            s4_pay_reg.pos      <= s3_pay_reg.pos;
            s4_pay_reg.over     <= s3_pay_reg.over;
            s4_pay_reg.full     <= s3_pay_reg.full;
            s4_pay_reg.den_zero <= s3_pay_reg.den_zero;
            s4_pay_reg.dvp      <= PW'(control_period_reg) * PW'(s3_ades_reg);
        end
    end

    // ---------------- weight divider ----------------
    logic               dw_valid;
    logic [61:0]        dw_quo;
    logic [30:0]        dw_rem;
    jlbp_pkg::wgt_pay_t dw_pay;

    jlbp_div #(.NUM_W(62), .DEN_W(31), .PAY_W($bits(jlbp_pkg::wgt_pay_t))) u_div_weight (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .in_valid(s4_valid_reg), .num(s4_wnum_reg), .den(s4_den_reg), .pay(s4_pay_reg),
        .out_valid(dw_valid), .quo(dw_quo), .rem(dw_rem), .out_pay(dw_pay)
    );

    // ---------------- stage 5: weight cap, velocity update, output register ----------------
    logic [30:0]          fin_w;
    logic signed [SW-1:0] fin_vs, fin_dv, fin_sum;
    logic signed [31:0]   fin_vel;
    logic [2:0]           fin_case;

    always_comb begin
        if (!dw_pay.over) begin
            fin_w = '0;
        end else if (dw_pay.full || dw_pay.den_zero) begin
            fin_w = weight_ceiling_reg;
        end else if (dw_quo > 62'(weight_ceiling_reg)) begin
            fin_w = weight_ceiling_reg;
        end else begin
            fin_w = dw_quo[30:0];
        end
    end

    assign fin_vs  = SW'(dw_pay.vel);
    assign fin_dv  = SW'(dw_pay.dvp >> FRAC_BITS);
    assign fin_sum = dw_pay.up ? (fin_vs - fin_dv) : (fin_vs + fin_dv);
    assign fin_vel = (fin_sum > SW'(32'sh7fffffff)) ? 32'sh7fffffff :
                     (fin_sum < -SW'(33'sh080000000)) ? 32'sh80000000 : fin_sum[31:0];

    always_comb begin
        if (!dw_pay.over) begin
            fin_case = jlbp_pkg::LC_FREE;
        end else if (dw_pay.up) begin
            fin_case = dw_pay.full ? jlbp_pkg::LC_AT_UPPER : jlbp_pkg::LC_NEAR_UPPER;
        end else begin
            fin_case = dw_pay.full ? jlbp_pkg::LC_AT_LOWER : jlbp_pkg::LC_NEAR_LOWER;
        end
    end

    logic         m_tvalid_reg;
    logic [103:0] m_tdata_reg;
    logic [3:0]   m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dw_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (dw_pay.inactive) begin
                m_tdata_reg <= {98'd0, dw_pay.jn};
                m_tuser_reg <= {jlbp_pkg::LC_FREE, 1'b0};
            end else begin
                m_tdata_reg <= {2'd0, 1'b0, fin_w, fin_vel, dw_pay.pos, dw_pay.jn};
                m_tuser_reg <= {fin_case, 1'b1};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* src/jlbp_checker.sv */
// Port-level checker for the braking planner, bound to the top level.
`include "joint_limit_braking_planner_unit_defines.svh"

module jlbp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic [3:0]   m_tuser
);

    // stalled result holds
    `JLBP_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")

    // a full stall back-pressures the input
    `JLBP_ASSERT_NOW(a_bp, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")

    // inactive joint carries only its echo
    `JLBP_ASSERT_NOW(a_inact, aclk, aresetn, m_tvalid && !m_tuser[0], m_tuser[3:1] == jlbp_pkg::LC_FREE && m_tdata[101:6] == 96'd0, "inactive result not cleared")

    // weight never negative, case code in range
    `JLBP_ASSERT_NOW(a_range, aclk, aresetn, m_tvalid, !m_tdata[101] && m_tuser[3:1] <= jlbp_pkg::LC_AT_LOWER, "weight or case out of range")

endmodule

bind joint_limit_braking_planner_unit jlbp_checker u_jlbp_checker (.*);

/* verif/joint_limit_braking_planner_unit_test.sv */
// Self-checking bench for the joint limit braking planner: directed table, then random joints.
module joint_limit_braking_planner_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    // register index that the block must ignore
    localparam logic [2:0] REG_UNMAPPED = 3'd5;
    localparam int         DRAIN_CYCLES = 2 * jlbp_pkg::VSQ_W + 20;

    typedef struct packed {
        logic [5:0]         jn;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [30:0]        amax;
    } joint_t;

    typedef struct packed {
        logic [5:0]         jn;
        logic               active;
        logic [2:0]         lcase;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] wt;
    } plan_t;

    typedef struct {
        joint_t joint;
        bit     typed;   // expectation written by hand
        plan_t  want;
    } row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    // shadow copy of the registers
    logic [30:0] buffer_factor;
    logic [30:0] weight_scale;
    logic [30:0] weight_ceiling;
    logic [16:0] control_period;

    plan_t pending_plans[$];
    int    error_count;
    int    joints_sent;
    int    plans_seen;
    int    case_hits[5];
    int    inactive_hits;
    int    send_idle_pct;
    int    recv_stall_pct;
    row_t  rows[14];

    joint_limit_braking_planner_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Braking plan for one joint under the current register values.
    function automatic plan_t plan_joint(joint_t q);
        longint     j, v, lo, hi, reach, vel;
        bit [63:0]  a, vmag, vsq, two_a, qt, rem, alim, diff, den, ades, w, dv;
        bit         up, over, full;
        plan_t      r;
        r = '0;
        r.jn = q.jn;
        j  = q.pos;
        v  = q.vel;
        lo = q.lo;
        hi = q.hi;
        if (hi <= lo)
            return r;
        a = (buffer_factor != 0) ?
            ((64'(q.amax) << jlbp_pkg::FRAC_BITS) / 64'(buffer_factor)) : 64'd0;
        vmag  = (v < 0) ? 64'(-v) : 64'(v);
        vsq   = vmag * vmag;
        up    = v > 0;
        reach = up ? (hi - j) : (j - lo);
        ades = 0;
        w    = 0;
        if (reach < 0) begin
            over = 1'b1;
        end else if (a == 0) begin
            over = vsq != 0;
        end else begin
            two_a = 2 * a;
            qt    = vsq / two_a;
            rem   = vsq % two_a;
            over  = qt > 64'(reach) || (qt == 64'(reach) && rem != 0);
        end
        r.lcase = jlbp_pkg::LC_FREE;
        if (over) begin
            full = 1'b1;
            if (reach > 0) begin
                alim = vsq / (2 * 64'(reach));
                if (alim <= 64'(q.amax)) begin
                    diff = (alim > a) ? alim - a : 64'd0;
                    den  = 64'(q.amax) - alim;
                    full = 1'b0;
                    ades = alim;
                    w    = (den == 0) ? 64'(weight_ceiling) : (64'(weight_scale) * diff) / den;
                end
            end
            if (full) begin
                ades = 64'(q.amax);
                w    = 64'(weight_ceiling);
            end
            if (up)
                r.lcase = full ? jlbp_pkg::LC_AT_UPPER : jlbp_pkg::LC_NEAR_UPPER;
            else
                r.lcase = full ? jlbp_pkg::LC_AT_LOWER : jlbp_pkg::LC_NEAR_LOWER;
        end
        if (w > 64'(weight_ceiling))
            w = 64'(weight_ceiling);
        dv  = (64'(control_period) * ades) >> jlbp_pkg::FRAC_BITS;
        vel = up ? v - longint'(dv) : v + longint'(dv);
        if (vel > 64'sd2147483647)
            vel = 64'sd2147483647;
        if (vel < -64'sd2147483648)
            vel = -64'sd2147483648;
        r.active = 1'b1;
        r.pos = (j > hi) ? q.hi : (j < lo) ? q.lo : q.pos;
        r.vel = vel[31:0];
        r.wt  = w[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("MISMATCH joint plan %0d: %s got %0d expected %0d", plans_seen, field, got, want);
        error_count++;
    endtask

    // Sender: idles at random, then holds the transaction until accepted.
    task automatic send_joint(joint_t q, bit typed, plan_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = {3'b000, q.amax, q.hi, q.lo, q.vel, q.pos, q.jn};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_plans.insert(pending_plans.size(), typed ? want : plan_joint(q));
        joints_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            jlbp_pkg::REG_BUFFER_FACTOR:  buffer_factor  = value[30:0];
            jlbp_pkg::REG_WEIGHT_SCALE:   weight_scale   = value[30:0];
            jlbp_pkg::REG_WEIGHT_CEILING: weight_ceiling = value[30:0];
            jlbp_pkg::REG_CONTROL_PERIOD: control_period = value[16:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Wait for every plan, then for the pipeline to settle.
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_plans.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Mostly well-formed joints aimed at the stopping-distance boundary;
    // the rest raw bit patterns and swapped limits.
    function automatic joint_t random_joint();
        joint_t  q;
        int      kind, pct;
        longint  gap, lo, alim, vsq, v;
        q.jn = 6'($urandom_range(0, 63));
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            q.pos  = $urandom;
            q.vel  = $urandom;
            q.lo   = $urandom;
            q.hi   = $urandom;
            q.amax = 31'($urandom);
        end else if (kind < 25) begin
            q.pos  = $urandom;
            q.vel  = $signed($urandom) >>> $urandom_range(0, 20);
            q.hi   = $urandom;
            q.lo   = q.hi + $urandom_range(0, 1000);
            q.amax = 31'($urandom);
            if (q.lo < q.hi)
                q.lo = q.hi;
        end else begin
            q.amax = 31'($urandom_range(1, 1 << $urandom_range(1, 24)));
            gap    = $urandom_range(0, 1 << $urandom_range(0, 22));
            pct    = $urandom_range(30, 130);
            alim   = (longint'(q.amax) * pct) / 100;
            vsq    = 2 * (gap == 0 ? 1 : gap) * alim;
            v      = longint'($sqrt(real'(vsq))) + $signed($urandom_range(0, 4)) - 2;
            if (v < 0)
                v = 0;
            if ($urandom_range(0, 9) == 0)
                v = $urandom_range(0, 1 << 30);
            lo   = $signed($urandom) >>> 3;
            q.lo = 32'(lo);
            q.hi = 32'(lo + gap + $urandom_range(1, 1 << 20));
            if ($urandom_range(0, 1)) begin
                q.vel = 32'(v);
                q.pos = 32'(q.hi - gap);
            end else begin
                q.vel = 32'(-v);
                q.pos = 32'(q.lo + gap);
            end
            // occasionally start outside the limits
            if ($urandom_range(0, 19) == 0)
                q.pos = q.pos + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        end
        return q;
    endfunction

    function automatic row_t mk_row(int jn, int pos, int vel, int lo, int hi, int amax);
        row_t r;
        r.joint = '{jn[5:0], pos, vel, lo, hi, amax[30:0]};
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // Receiver back-pressure.
    always @(negedge aclk)
        m_tready = ($urandom_range(0, 99) >= recv_stall_pct);

    // Result checker: every accepted transaction against the oldest plan.
    always @(posedge aclk) begin
        plan_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[5:0], m_tuser[0], m_tuser[3:1], m_tdata[37:6],
                   m_tdata[69:38], m_tdata[101:70]};
            if (pending_plans.size() == 0) begin
                $display("MISMATCH joint plan %0d: result with nothing pending", plans_seen);
                error_count++;
            end else begin
                want = pending_plans.pop_front();
                if (got.jn !== want.jn)         report_mismatch("joint_echo", got.jn, want.jn);
                if (got.active !== want.active) report_mismatch("active", got.active, want.active);
                if (got.lcase !== want.lcase)   report_mismatch("limit_case", got.lcase, want.lcase);
                if (got.pos !== want.pos)       report_mismatch("target_position", got.pos, want.pos);
                if (got.vel !== want.vel)       report_mismatch("target_velocity", got.vel, want.vel);
                if (got.wt !== want.wt)         report_mismatch("task_weight", got.wt, want.wt);
                if (!want.active)
                    inactive_hits++;
                else if (want.lcase <= jlbp_pkg::LC_AT_LOWER)
                    case_hits[want.lcase]++;
            end
            plans_seen++;
        end
    end

    // Run limit.
    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int idle_set[4][2];
        int per_phase;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = jlbp_pkg::REG_BUFFER_FACTOR;
        cfg_data  = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        joints_sent    = 0;
        plans_seen     = 0;
        inactive_hits  = 0;
        foreach (case_hits[k]) case_hits[k] = 0;
        buffer_factor  = jlbp_pkg::BUFFER_FACTOR_RST;
        weight_scale   = jlbp_pkg::WEIGHT_SCALE_RST;
        weight_ceiling = jlbp_pkg::WEIGHT_CEILING_RST;
        control_period = jlbp_pkg::CONTROL_PERIOD_RST;

        // sender idle / receiver stall percentages per phase
        idle_set = '{'{0, 0}, '{86, 0}, '{0, 86}, '{36, 36}};

        // Directed table, default registers.
        rows[0]  = mk_row(0, 0, 0, -65536, 65536, 65536);          // at rest, free
        rows[0].typed = 1'b1;
        rows[0].want  = '{6'd0, 1'b1, jlbp_pkg::LC_FREE, 32'sd0, 32'sd0, 32'sd0};
        rows[1]  = mk_row(1, 5, 7, 100, 100, 1);                    // equal limits
        rows[1].typed = 1'b1;
        rows[1].want  = '{6'd1, 1'b0, jlbp_pkg::LC_FREE, 32'sd0, 32'sd0, 32'sd0};
        rows[2]  = mk_row(63, 32'h8000_0000, 32'h7fff_ffff,         // swapped extreme limits
                          32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        rows[2].typed = 1'b1;
        rows[2].want  = '{6'd63, 1'b0, jlbp_pkg::LC_FREE, 32'sd0, 32'sd0, 32'sd0};
        rows[3]  = mk_row(2, 65536, 65536, 0, 65536, 65536);        // sitting on upper limit
        rows[3].typed = 1'b1;
        rows[3].want  = '{6'd2, 1'b1, jlbp_pkg::LC_AT_UPPER, 32'sd65536, 32'sd64881,
                          32'sd655360};
        rows[4]  = mk_row(3, 0, -65536, 0, 65536, 65536);           // sitting on lower limit
        rows[4].typed = 1'b1;
        rows[4].want  = '{6'd3, 1'b1, jlbp_pkg::LC_AT_LOWER, 32'sd0, -32'sd64881,
                          32'sd655360};
        rows[5]  = mk_row(4, 200000, 65536, 0, 131072, 65536);      // past upper, clamped
        rows[5].typed = 1'b1;
        rows[5].want  = '{6'd4, 1'b1, jlbp_pkg::LC_AT_UPPER, 32'sd131072, 32'sd64881,
                          32'sd655360};
        rows[6]  = mk_row(5, 0, 1000, -65536, 65536, 0);            // no decel, moving
        rows[6].typed = 1'b1;
        rows[6].want  = '{6'd5, 1'b1, jlbp_pkg::LC_AT_UPPER, 32'sd0, 32'sd1000, 32'sd655360};
        rows[7]  = mk_row(6, 0, 0, -65536, 65536, 0);               // no decel, still
        rows[7].typed = 1'b1;
        rows[7].want  = '{6'd6, 1'b1, jlbp_pkg::LC_FREE, 32'sd0, 32'sd0, 32'sd0};
        rows[8]  = mk_row(7, 0, 80264, -65536, 65536, 65536);       // near upper
        rows[9]  = mk_row(8, 0, 4, -65536, 2, 4);                   // braking equals max decel
        rows[10] = mk_row(9, 32'h7fff_ffff, 32'h8000_0000,          // extremes, toward lower
                          32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        rows[11] = mk_row(10, 32'h8000_0000, 32'h7fff_ffff,         // extremes, toward upper
                          32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        rows[12] = mk_row(63, 0, -80264, -65536, 65536, 65536);     // near lower
        rows[13] = mk_row(11, -100, 0, 0, 65536, 1);                // below lower, still

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i])
            send_joint(rows[i].joint, rows[i].typed, rows[i].want);
        drain();

        per_phase = 370;
        for (int ph = 0; ph < 4; ph++) begin
            // registers only change with the pipeline empty
            case (ph)
                0: begin
                    write_reg(jlbp_pkg::REG_BUFFER_FACTOR, 32'd1);
                    write_reg(jlbp_pkg::REG_WEIGHT_SCALE, 32'h7fff_ffff);
                    write_reg(jlbp_pkg::REG_WEIGHT_CEILING, 32'h7fff_ffff);
                    write_reg(jlbp_pkg::REG_CONTROL_PERIOD, 32'd65536);
                end
                1: begin
                    write_reg(jlbp_pkg::REG_BUFFER_FACTOR, 32'h7fff_ffff);
                    write_reg(jlbp_pkg::REG_WEIGHT_SCALE, 32'd0);
                    write_reg(jlbp_pkg::REG_WEIGHT_CEILING, 32'd0);
                    write_reg(jlbp_pkg::REG_CONTROL_PERIOD, 32'd1);
                    write_reg(REG_UNMAPPED, $urandom);
                end
                2: begin
                    write_reg(jlbp_pkg::REG_BUFFER_FACTOR, 32'(jlbp_pkg::BUFFER_FACTOR_RST));
                    write_reg(jlbp_pkg::REG_WEIGHT_SCALE, 32'(jlbp_pkg::WEIGHT_SCALE_RST));
                    write_reg(jlbp_pkg::REG_WEIGHT_CEILING, 32'(jlbp_pkg::WEIGHT_CEILING_RST));
                    write_reg(jlbp_pkg::REG_CONTROL_PERIOD, 32'(jlbp_pkg::CONTROL_PERIOD_RST));
                end
                default: begin
                    write_reg(jlbp_pkg::REG_BUFFER_FACTOR, $urandom_range(1, 1 << 20));
                    write_reg(jlbp_pkg::REG_WEIGHT_SCALE, $urandom_range(0, 32'h7fff_ffff));
                    write_reg(jlbp_pkg::REG_WEIGHT_CEILING, $urandom_range(0, 32'h7fff_ffff));
                    write_reg(jlbp_pkg::REG_CONTROL_PERIOD, $urandom_range(1, 65536));
                end
            endcase
            send_idle_pct  = idle_set[ph][0];
            recv_stall_pct = idle_set[ph][1];
            for (int n = 0; n < per_phase; n++) begin
                // sender holds off mid-phase until the pipeline empties
                if (n == per_phase / 2)
                    drain();
                send_joint(random_joint(), 1'b0, '0);
            end
            drain();
        end

        $display("Covered %0d joints: free %0d, near upper %0d, at upper %0d, near lower %0d,",
                 joints_sent, case_hits[jlbp_pkg::LC_FREE], case_hits[jlbp_pkg::LC_NEAR_UPPER],
                 case_hits[jlbp_pkg::LC_AT_UPPER], case_hits[jlbp_pkg::LC_NEAR_LOWER]);
        $display("at lower %0d, invalid limits %0d, over five register settings.",
                 case_hits[jlbp_pkg::LC_AT_LOWER], inactive_hits);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
